>>> rtl/core/size_class_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// Size-class pool allocator assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication
`define SCPA_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SCPA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/scpa_pkg.sv
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared constants, codes and types of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int unsigned POOLS          = 4;
  localparam int unsigned SLOTS_PER_POOL = 64;
  localparam int unsigned BASE_PAYLOAD   = 32;

  localparam int unsigned POOL_W   = 2;
  localparam int unsigned PCNT_W   = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned CAP_W    = 9;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam int unsigned STORE_DEPTH = POOLS * SLOTS_PER_POOL;
  localparam int unsigned STORE_AW    = POOL_W + SLOT_W;

  localparam logic [PCNT_W-1:0] POOLS_RST = 3'd4;
  localparam logic [CNT_W-1:0]  SLOTS_RST = 7'd16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_BAD_SIZE   = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_LIST_FULL  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_POOLS_IN_USE     = 3'd0,
    REG_SLOTS_POOL_ZERO  = 3'd1,
    REG_SLOTS_POOL_ONE   = 3'd2,
    REG_SLOTS_POOL_TWO   = 3'd3,
    REG_SLOTS_POOL_THREE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [PCNT_W-1:0]            pools_in_use;
    logic [POOLS-1:0][CNT_W-1:0]  slots;
  } cfg_t;

  typedef struct packed {
    cmd_e               command;
    logic [SIZE_W-1:0]  size;
    logic [POOL_W-1:0]  pool;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [POOL_W-1:0]  pool;
    logic [SLOT_W-1:0]  slot;
    logic [CAP_W-1:0]   cap;
    logic [CNT_W-1:0]   use_cnt;
    logic [CNT_W-1:0]   peak;
    logic               pop;
    logic               hit;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [STORE_AW-1:0]  waddr;
    logic [SLOT_W-1:0]    wdata;
    logic                 re;
    logic [STORE_AW-1:0]  raddr;
  } ram_req_t;

  // Payload bytes of one buffer in pool p
  function automatic logic [CAP_W-1:0] cap_of(input logic [POOL_W-1:0] p);
    return CAP_W'(BASE_PAYLOAD) << p;
  endfunction

endpackage

>>> rtl/core/size_class_pool_allocator.sv
// ----------------------------------------------------------------------------
// size_class_pool_allocator
// Buffer pools of 32, 64, 128 and 256 bytes with a FIFO free list each.
// A transaction is taken when start is high and busy is low; through the
// input register and the result register, its result appears on the result
// ports for one cycle, marked by result_strobe_o. While busy is low, a new
// transaction can be taken every cycle, so one result per cycle comes out;
// the receiver cannot stall it. A popped slot comes from the free-list RAM's
// registered read. A write to a defined register reloads all free lists and
// counters in the following cycle, during which busy is high.
// ----------------------------------------------------------------------------
`include "size_class_pool_allocator_assert.svh"

module size_class_pool_allocator import scpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [SIZE_W-1:0]  request_size_i,
  input  logic [POOL_W-1:0]  pool_index_i,
  input  logic [SLOT_W-1:0]  slot_index_i,
  // Result channel
  output logic               result_strobe_o,
  output logic [2:0]         status_o,
  output logic [POOL_W-1:0]  granted_pool_o,
  output logic [SLOT_W-1:0]  granted_slot_o,
  output logic [CAP_W-1:0]   capacity_o,
  output logic [CNT_W-1:0]   in_use_count_o,
  output logic [CNT_W-1:0]   peak_in_use_o,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t        cfg;
  logic        init;
  logic        accept;
  logic        item_valid_q;
  req_t        item_q;
  res_t        res;
  res_t        res_q;
  logic        result_strobe_q;
  ram_req_t    ram_req;
  logic [SLOT_W-1:0] ram_rdata;

  assign pready = 1'b1;
  assign busy   = init;
  assign accept = start & ~busy;

  scpa_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg),
    .init_o    (init)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.command <= cmd_e'(command_i);
      item_q.size    <= request_size_i;
      item_q.pool    <= pool_index_i;
      item_q.slot    <= slot_index_i;
    end
  end

  scpa_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .init_i       (init),
    .item_valid_i (item_valid_q),
    .item_i       (item_q),
    .res_o        (res),
    .ram_o        (ram_req)
  );

  scpa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (STORE_DEPTH)
  ) u_free_list (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_q <= 1'b0;
    end else begin
      result_strobe_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_q) begin
      res_q <= res;
    end
  end

  // Drive result ports; a popped slot comes from the RAM once written
  assign result_strobe_o = result_strobe_q;
  assign status_o        = res_q.status;
  assign granted_pool_o  = res_q.pool;
  assign granted_slot_o  = (res_q.pop && res_q.hit) ? ram_rdata : res_q.slot;
  assign capacity_o      = res_q.cap;
  assign in_use_count_o  = res_q.use_cnt;
  assign peak_in_use_o   = res_q.peak;

  // Checks
  `SCPA_ASSERT_NEXT(a_item_gives_result, item_valid_q, result_strobe_q, "result lost")
  `SCPA_ASSERT_IMPLIES(a_result_from_item, result_strobe_q, $past(item_valid_q), "stray result")
  `SCPA_ASSERT_IMPLIES(a_ok_has_capacity, result_strobe_q && (res_q.status == ST_OK), res_q.cap != '0, "zero capacity on success")
  `SCPA_ASSERT_IMPLIES(a_peak_covers_use, result_strobe_q, res_q.peak >= res_q.use_cnt, "peak below in-use count")

endmodule

>>> rtl/core/scpa_ram.sv
// ----------------------------------------------------------------------------
// scpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/scpa_regs.sv
// ----------------------------------------------------------------------------
// scpa_regs
// Configuration register file behind the APB-style port; flags a pool
// re-initialization after every write to a defined register.
// ----------------------------------------------------------------------------
module scpa_regs import scpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  output cfg_t               cfg_o,
  output logic               init_o
);

  cfg_t     cfg_q, cfg_d;
  logic     init_q, init_d;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = reg_idx_e'(paddr_i[PADDR_W-1:2]);

  // Decode register writes
  always_comb begin
    cfg_d  = cfg_q;
    init_d = 1'b0;
    if (wr_en) begin
      init_d = 1'b1;
      unique case (idx)
        REG_POOLS_IN_USE:     cfg_d.pools_in_use = pwdata_i[PCNT_W-1:0];
        REG_SLOTS_POOL_ZERO:  cfg_d.slots[0] = pwdata_i[CNT_W-1:0];
        REG_SLOTS_POOL_ONE:   cfg_d.slots[1] = pwdata_i[CNT_W-1:0];
        REG_SLOTS_POOL_TWO:   cfg_d.slots[2] = pwdata_i[CNT_W-1:0];
        REG_SLOTS_POOL_THREE: cfg_d.slots[3] = pwdata_i[CNT_W-1:0];
        default:              init_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pools_in_use <= POOLS_RST;
      for (int p = 0; p < POOLS; p++) begin
        cfg_q.slots[p] <= SLOTS_RST;
      end
      init_q <= 1'b0;
    end else begin
      cfg_q  <= cfg_d;
      init_q <= init_d;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_POOLS_IN_USE:     prdata_o = PDATA_W'(cfg_q.pools_in_use);
      REG_SLOTS_POOL_ZERO:  prdata_o = PDATA_W'(cfg_q.slots[0]);
      REG_SLOTS_POOL_ONE:   prdata_o = PDATA_W'(cfg_q.slots[1]);
      REG_SLOTS_POOL_TWO:   prdata_o = PDATA_W'(cfg_q.slots[2]);
      REG_SLOTS_POOL_THREE: prdata_o = PDATA_W'(cfg_q.slots[3]);
      default:              prdata_o = '0;
    endcase
  end

  assign cfg_o  = cfg_q;
  assign init_o = init_q;

endmodule

>>> rtl/core/scpa_engine.sv
// ----------------------------------------------------------------------------
// scpa_engine
// Per-pool free-list pointers and counters; decides one allocate or free
// transaction per cycle and drives the free-list RAM.
// ----------------------------------------------------------------------------
module scpa_engine import scpa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     init_i,
  input  logic     item_valid_i,
  input  req_t     item_i,
  output res_t     res_o,
  output ram_req_t ram_o
);

  logic [PCNT_W-1:0]           np;
  logic [POOLS-1:0][CNT_W-1:0] nslots;
  logic [POOLS-1:0][CNT_W-1:0] init_n;

  logic [POOLS-1:0][SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [POOLS-1:0][CNT_W-1:0]  fill_q, fill_d, use_q, use_d, peak_q, peak_d;
  logic [STORE_DEPTH-1:0]       valid_q, valid_d;

  logic [POOLS-1:0]    fits;
  logic                found;
  logic [POOL_W-1:0]   apool;
  logic [POOL_W-1:0]   fpool;
  logic                handle_ok;
  logic                list_full;
  logic [CNT_W-1:0]    use_inc, use_dec, peak_new;
  logic [STORE_AW-1:0] rd_addr, wr_addr;

  // Clamp configuration to the supported range
  always_comb begin
    np = (cfg_i.pools_in_use > PCNT_W'(POOLS)) ? PCNT_W'(POOLS) : cfg_i.pools_in_use;
    for (int p = 0; p < POOLS; p++) begin
      nslots[p] = (cfg_i.slots[p] > CNT_W'(SLOTS_PER_POOL)) ?
                  CNT_W'(SLOTS_PER_POOL) : cfg_i.slots[p];
      init_n[p] = (PCNT_W'(p) < np) ? nslots[p] : '0;
    end
  end

  // Pick the smallest enabled pool that holds the request
  always_comb begin
    found = 1'b0;
    apool = '0;
    for (int p = 0; p < POOLS; p++) begin
      fits[p] = (PCNT_W'(p) < np) && (item_i.size != '0) &&
                (item_i.size <= SIZE_W'(cap_of(POOL_W'(p))));
    end
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (fits[p]) begin
        found = 1'b1;
        apool = POOL_W'(p);
      end
    end
  end

  // Handle checks for free
  assign fpool     = item_i.pool;
  assign handle_ok = ({1'b0, fpool} < np) && (CNT_W'(item_i.slot) < nslots[fpool]);
  assign list_full = (fill_q[fpool] >= nslots[fpool]) || (use_q[fpool] == '0);

  assign use_inc  = use_q[apool] + CNT_W'(1);
  assign use_dec  = use_q[fpool] - CNT_W'(1);
  assign peak_new = (use_inc > peak_q[apool]) ? use_inc : peak_q[apool];
  assign rd_addr  = {apool, head_q[apool]};
  assign wr_addr  = {fpool, tail_q[fpool]};

  // Decide the transaction and the next pool state
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    use_d   = use_q;
    peak_d  = peak_q;
    valid_d = valid_q;
    res_o   = '0;
    ram_o   = '0;
    res_o.status = ST_OK;
    ram_o.raddr  = rd_addr;
    ram_o.waddr  = wr_addr;
    ram_o.wdata  = item_i.slot;
    unique case (item_i.command)
      CMD_ALLOC: begin
        if (!found) begin
          res_o.status = ST_BAD_SIZE;
        end else if (fill_q[apool] == '0) begin
          res_o.status  = ST_EMPTY;
          res_o.pool    = apool;
          res_o.use_cnt = use_q[apool];
          res_o.peak    = peak_q[apool];
        end else begin
          // Pop the head; an entry never written holds its own position
          res_o.pool    = apool;
          res_o.slot    = rd_addr[SLOT_W-1:0];
          res_o.cap     = cap_of(apool);
          res_o.use_cnt = use_inc;
          res_o.peak    = peak_new;
          res_o.pop     = 1'b1;
          res_o.hit     = valid_q[rd_addr];
          ram_o.re      = item_valid_i;
          if (item_valid_i) begin
            head_d[apool] = head_q[apool] + SLOT_W'(1);
            fill_d[apool] = fill_q[apool] - CNT_W'(1);
            use_d[apool]  = use_inc;
            peak_d[apool] = peak_new;
          end
        end
      end
      CMD_FREE: begin
        if (!handle_ok) begin
          res_o.status = ST_BAD_HANDLE;
        end else if (list_full) begin
          res_o.status  = ST_LIST_FULL;
          res_o.pool    = fpool;
          res_o.slot    = item_i.slot;
          res_o.use_cnt = use_q[fpool];
          res_o.peak    = peak_q[fpool];
        end else begin
          // Push the slot at the tail
          res_o.pool    = fpool;
          res_o.slot    = item_i.slot;
          res_o.cap     = cap_of(fpool);
          res_o.use_cnt = use_dec;
          res_o.peak    = peak_q[fpool];
          ram_o.we      = item_valid_i;
          if (item_valid_i) begin
            tail_d[fpool]    = tail_q[fpool] + SLOT_W'(1);
            fill_d[fpool]    = fill_q[fpool] + CNT_W'(1);
            use_d[fpool]     = use_dec;
            valid_d[wr_addr] = 1'b1;
          end
        end
      end
      default: res_o.status = ST_BAD_HANDLE;
    endcase
  end

  // Pool state; reset and every write to a defined register reload the free lists
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < POOLS; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= (PCNT_W'(p) < POOLS_RST) ? SLOTS_RST[SLOT_W-1:0] : '0;
        fill_q[p] <= (PCNT_W'(p) < POOLS_RST) ? SLOTS_RST : '0;
        use_q[p]  <= '0;
        peak_q[p] <= '0;
      end
      valid_q <= '0;
    end else if (init_i) begin
      for (int p = 0; p < POOLS; p++) begin
        head_q[p] <= '0;
        tail_q[p] <= init_n[p][SLOT_W-1:0];
        fill_q[p] <= init_n[p];
        use_q[p]  <= '0;
        peak_q[p] <= '0;
      end
      valid_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      use_q   <= use_d;
      peak_q  <= peak_d;
      valid_q <= valid_d;
    end
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-class pool allocator. A predictor keeps
// its own copy of the free lists, the counters and the configuration, and
// queues one expected grant per accepted command. A checker compares each
// strobed grant with the oldest expectation, field by field. Traffic covers
// directed corner cases, then alloc/free churn under many register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import scpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam logic [2:0]  UNMAPPED_IDX = 3'd5;

  typedef struct packed {
    status_e            status;
    logic [POOL_W-1:0]  pool;
    logic [SLOT_W-1:0]  slot;
    logic [CAP_W-1:0]   cap;
    logic [CNT_W-1:0]   use_cnt;
    logic [CNT_W-1:0]   peak;
  } grant_t;

  typedef struct packed {
    logic [POOL_W-1:0]  pool;
    logic [SLOT_W-1:0]  slot;
  } handle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               command_i;
  logic [SIZE_W-1:0]  request_size_i;
  logic [POOL_W-1:0]  pool_index_i;
  logic [SLOT_W-1:0]  slot_index_i;
  logic               result_strobe_o;
  logic [2:0]         status_o;
  logic [POOL_W-1:0]  granted_pool_o;
  logic [SLOT_W-1:0]  granted_slot_o;
  logic [CAP_W-1:0]   capacity_o;
  logic [CNT_W-1:0]   in_use_count_o;
  logic [CNT_W-1:0]   peak_in_use_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predictor state
  logic [PCNT_W-1:0]  cfg_pools;
  logic [CNT_W-1:0]   cfg_slots [POOLS];
  logic [SLOT_W-1:0]  free_store [POOLS][SLOTS_PER_POOL];
  int unsigned        list_head [POOLS];
  int unsigned        list_tail [POOLS];
  int unsigned        list_fill [POOLS];
  int unsigned        used_cnt [POOLS];
  int unsigned        used_peak [POOLS];

  grant_t             grant_expect_q [$];
  handle_t            held_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        grant_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        calm_left = 0;

  size_class_pool_allocator u_top (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .command_i,
    .request_size_i,
    .pool_index_i,
    .slot_index_i,
    .result_strobe_o,
    .status_o,
    .granted_pool_o,
    .granted_slot_o,
    .capacity_o,
    .in_use_count_o,
    .peak_in_use_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on grant %0d: %s got %0d want %0d", grant_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned live_pools();
    return (cfg_pools > POOLS) ? POOLS : int'(cfg_pools);
  endfunction

  function automatic int unsigned live_slots(input int unsigned p);
    return (cfg_slots[p] > SLOTS_PER_POOL) ? SLOTS_PER_POOL : int'(cfg_slots[p]);
  endfunction

  function automatic int unsigned wrap_next(input int unsigned x);
    return (x + 1 >= SLOTS_PER_POOL) ? 0 : x + 1;
  endfunction

  // Refill every free list in slot order and clear the counters
  function automatic void reload_pools();
    int unsigned n;
    for (int p = 0; p < POOLS; p++) begin
      n = (p < live_pools()) ? live_slots(p) : 0;
      for (int k = 0; k < SLOTS_PER_POOL; k++)
        free_store[p][k] = (k < n) ? SLOT_W'(k) : '0;
      list_head[p] = 0;
      list_tail[p] = n % SLOTS_PER_POOL;
      list_fill[p] = n;
      used_cnt[p]  = 0;
      used_peak[p] = 0;
    end
  endfunction

  function automatic void settings_at_reset();
    cfg_pools = POOLS_RST;
    for (int p = 0; p < POOLS; p++)
      cfg_slots[p] = SLOTS_RST;
    reload_pools();
  endfunction

  // Apply a register write; unmapped indexes change nothing
  function automatic void settings_write(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_POOLS_IN_USE:     cfg_pools    = data[PCNT_W-1:0];
      REG_SLOTS_POOL_ZERO:  cfg_slots[0] = data[CNT_W-1:0];
      REG_SLOTS_POOL_ONE:   cfg_slots[1] = data[CNT_W-1:0];
      REG_SLOTS_POOL_TWO:   cfg_slots[2] = data[CNT_W-1:0];
      REG_SLOTS_POOL_THREE: cfg_slots[3] = data[CNT_W-1:0];
      default:              return;
    endcase
    reload_pools();
    held_q.delete();
  endfunction

  function automatic logic [31:0] settings_value(input logic [2:0] idx);
    if (idx == REG_POOLS_IN_USE)
      return 32'(cfg_pools);
    return 32'(cfg_slots[idx - 1]);
  endfunction

  // Work out the grant of one command and advance the pool state
  function automatic grant_t predict_grant(input req_t rq);
    grant_t      g;
    int unsigned np;
    int unsigned p;
    bit          found;
    g     = '0;
    np    = live_pools();
    p     = 0;
    found = 1'b0;
    if (rq.command == CMD_ALLOC) begin
      if (rq.size != 0) begin
        for (int i = 0; i < np; i++) begin
          if (!found && rq.size <= (BASE_PAYLOAD << i)) begin
            found = 1'b1;
            p     = i;
          end
        end
      end
      if (!found) begin
        g.status = ST_BAD_SIZE;
        return g;
      end
      g.pool = POOL_W'(p);
      if (list_fill[p] == 0) begin
        g.status  = ST_EMPTY;
        g.use_cnt = CNT_W'(used_cnt[p]);
        g.peak    = CNT_W'(used_peak[p]);
        return g;
      end
      g.slot       = free_store[p][list_head[p]];
      list_head[p] = wrap_next(list_head[p]);
      list_fill[p]--;
      used_cnt[p]++;
      if (used_cnt[p] > used_peak[p])
        used_peak[p] = used_cnt[p];
      g.status  = ST_OK;
      g.cap     = CAP_W'(BASE_PAYLOAD << p);
      g.use_cnt = CNT_W'(used_cnt[p]);
      g.peak    = CNT_W'(used_peak[p]);
      return g;
    end
    p = rq.pool;
    if (p >= np || rq.slot >= live_slots(p)) begin
      g.status = ST_BAD_HANDLE;
      return g;
    end
    g.pool = rq.pool;
    g.slot = rq.slot;
    if (list_fill[p] >= live_slots(p) || used_cnt[p] == 0) begin
      g.status  = ST_LIST_FULL;
      g.use_cnt = CNT_W'(used_cnt[p]);
      g.peak    = CNT_W'(used_peak[p]);
      return g;
    end
    free_store[p][list_tail[p]] = rq.slot;
    list_tail[p] = wrap_next(list_tail[p]);
    list_fill[p]++;
    used_cnt[p]--;
    g.status  = ST_OK;
    g.cap     = CAP_W'(BASE_PAYLOAD << p);
    g.use_cnt = CNT_W'(used_cnt[p]);
    g.peak    = CNT_W'(used_peak[p]);
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Grant checker: compare each strobed grant with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_grants
    grant_t want;
    if (rst_ni === 1'b1 && result_strobe_o !== 1'b0) begin
      grant_count++;
      if (grant_expect_q.size() == 0) begin
        flag_mismatch("grant with none expected, status", status_o, 0);
      end else begin
        want = grant_expect_q.pop_front();
        if (result_strobe_o !== 1'b1)
          flag_mismatch("strobe not 0/1, strobe", result_strobe_o, 1);
        if (status_o !== want.status)
          flag_mismatch("status", status_o, want.status);
        if (granted_pool_o !== want.pool)
          flag_mismatch("granted_pool", granted_pool_o, want.pool);
        if (granted_slot_o !== want.slot)
          flag_mismatch("granted_slot", granted_slot_o, want.slot);
        if (capacity_o !== want.cap)
          flag_mismatch("capacity", capacity_o, want.cap);
        if (in_use_count_o !== want.use_cnt)
          flag_mismatch("in_use_count", in_use_count_o, want.use_cnt);
        if (peak_in_use_o !== want.peak)
          flag_mismatch("peak_in_use", peak_in_use_o, want.peak);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------
  // Pick the idle gap after a transaction: mostly none or short, a few long
  function automatic int unsigned next_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50)
      return 0;
    if (r < 88)
      return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Send one command; called and returns at a falling edge
  task automatic send_item(input cmd_e cmd, input logic [SIZE_W-1:0] size,
                           input logic [POOL_W-1:0] pool,
                           input logic [SLOT_W-1:0] slot);
    req_t        rq;
    grant_t      g;
    int unsigned gap;
    rq.command     = cmd;
    rq.size        = size;
    rq.pool        = pool;
    rq.slot        = slot;
    command_i      = cmd;
    request_size_i = size;
    pool_index_i   = pool;
    slot_index_i   = slot;
    start          = 1'b1;
    // Hold until the block takes the transaction
    do @(posedge clk_i); while (busy !== 1'b0);
    g = predict_grant(rq);
    grant_expect_q.push_back(g);
    if (cmd == CMD_ALLOC && g.status == ST_OK)
      held_q.push_back({g.pool, g.slot});
    @(negedge clk_i);
    gap = next_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_alloc(input logic [SIZE_W-1:0] size);
    send_item(CMD_ALLOC, size, POOL_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 63)));
  endtask

  task automatic send_free(input logic [POOL_W-1:0] pool, input logic [SLOT_W-1:0] slot);
    send_item(CMD_FREE, SIZE_W'($urandom_range(0, 65535)), pool, slot);
  endtask

  // Drop start and let every pending grant drain
  task automatic wait_idle();
    start = 1'b0;
    while (grant_expect_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    settings_write(idx, data);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_check_reg(input logic [2:0] idx);
    logic [31:0] got;
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== settings_value(idx))
      flag_mismatch("register readback", got, settings_value(idx));
  endtask

  // Write all registers, some with junk above the field, then read them back
  task automatic apply_config(input int unsigned pools, input int unsigned s0,
                              input int unsigned s1, input int unsigned s2,
                              input int unsigned s3);
    logic [31:0] vals [5];
    logic [31:0] mask;
    vals = '{pools, s0, s1, s2, s3};
    for (int i = 0; i < 5; i++) begin
      mask = (i == REG_POOLS_IN_USE) ? 32'h7 : 32'h7F;
      if ($urandom_range(0, 2) == 0)
        write_reg(3'(i), vals[i] | ($urandom() & ~mask));
      else
        write_reg(3'(i), vals[i]);
    end
    for (int i = 0; i < 5; i++)
      read_check_reg(3'(i));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Byte size that lands in size class c
  function automatic logic [SIZE_W-1:0] class_size(input int unsigned c);
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    lo = (c == 0) ? 1 : (BASE_PAYLOAD << (c - 1)) + 1;
    hi = BASE_PAYLOAD << c;
    r  = $urandom_range(0, 9);
    if (r == 0)
      return SIZE_W'(lo);
    if (r == 1)
      return SIZE_W'(hi);
    return SIZE_W'($urandom_range(lo, hi));
  endfunction

  // Alloc/free churn with random content, plus some malformed commands
  task automatic random_traffic(input int unsigned n);
    int unsigned pct;
    int unsigned np;
    int unsigned ns;
    int unsigned idx;
    handle_t     h;
    pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       pct = 20;
          1:       pct = 50;
          default: pct = 85;
        endcase
      end
      np = live_pools();
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 3))
          0: send_alloc(SIZE_W'($urandom_range(0, 65535)));
          1: begin
            if (np == 0 || $urandom_range(0, 3) == 0)
              send_alloc('0);
            else
              send_alloc(SIZE_W'((BASE_PAYLOAD << (np - 1)) + $urandom_range(1, 300)));
          end
          2: send_free(POOL_W'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 63)));
          default: begin
            h.pool = (np == 0) ? '0 : POOL_W'($urandom_range(0, np - 1));
            ns     = live_slots(h.pool);
            h.slot = (ns == 0) ? '0 : SLOT_W'($urandom_range(0, ns - 1));
            send_free(h.pool, h.slot);
          end
        endcase
      end else if (held_q.size() == 0 || $urandom_range(0, 99) < pct) begin
        send_alloc(class_size((np == 0) ? $urandom_range(0, 3) : $urandom_range(0, np - 1)));
      end else begin
        idx = $urandom_range(0, held_q.size() - 1);
        h   = held_q[idx];
        held_q.delete(idx);
        send_free(h.pool, h.slot);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_values();
    for (int i = 0; i < 5; i++)
      read_check_reg(3'(i));
  endtask

  // Class boundaries, bad size, bad handle, empty pool and full free list
  task automatic test_directed();
    send_alloc(16'd1);
    send_alloc(16'd32);
    send_alloc(16'd33);
    send_alloc(16'd64);
    send_alloc(16'd65);
    send_alloc(16'd128);
    send_alloc(16'd129);
    send_alloc(16'd256);
    send_alloc(16'd257);
    send_alloc(16'd0);
    send_alloc(16'hFFFF);
    send_free(2'd0, 6'd1);
    send_free(2'd3, 6'd63);
    send_free(2'd3, 6'd0);
    send_free(2'd3, 6'd1);
    send_free(2'd3, 6'd1);
    send_free(2'd2, 6'd40);
    // One pool of one buffer
    apply_config(1, 1, 16, 16, 16);
    send_alloc(16'd1);
    send_alloc(16'd32);
    send_alloc(16'd33);
    send_free(2'd1, 6'd0);
    send_free(2'd0, 6'd0);
    send_free(2'd0, 6'd0);
  endtask

  // No pool enabled, and a pool count above the pool number
  task automatic test_pool_count_extremes();
    apply_config(0, 16, 16, 16, 16);
    random_traffic(40);
    apply_config(7, 127, 1, 0, 64);
    random_traffic(150);
    // An unmapped register write leaves state alone
    write_reg(UNMAPPED_IDX, $urandom());
    random_traffic(30);
  endtask

  // Empty pools, single-buffer pools and counts above the slot limit
  task automatic test_slot_count_extremes();
    apply_config(1, 0, 64, 64, 64);
    random_traffic(40);
    apply_config(4, 1, 1, 1, 1);
    random_traffic(100);
    apply_config(4, 0, 0, 0, 127);
    random_traffic(80);
  endtask

  // Long churn in mixed settings so the circular lists wrap many times
  task automatic test_churn();
    apply_config(4, 64, 64, 64, 64);
    random_traffic(250);
    apply_config(2, 5, 3, 16, 16);
    random_traffic(150);
    apply_config(3, 64, 2, 127, 9);
    random_traffic(200);
    apply_config(4, 33, 17, 64, 8);
    random_traffic(200);
    apply_config(4, 64, 64, 64, 64);
    random_traffic(380);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_ALLOC;
    request_size_i = '0;
    pool_index_i   = '0;
    slot_index_i   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    settings_at_reset();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_directed();
    test_pool_count_extremes();
    test_slot_count_extremes();
    test_churn();

    // Drain and let the pipeline settle
    start = 1'b0;
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
